// ===== design/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

  localparam int QueueDepth    = 16;
  localparam int DataWidth     = 32;
  localparam int PriorityWidth = 16;
  localparam int CountWidth    = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_NOP  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic                            push_en;
    logic                            pop_en;
    logic signed [PriorityWidth-1:0] prio;
    logic        [DataWidth-1:0]     data;
  } spq_cmd_t;

  // What a cell hands to its neighbors.
  typedef struct packed {
    logic                            ge;
    logic signed [PriorityWidth-1:0] prio;
    logic        [DataWidth-1:0]     data;
  } spq_link_t;

endpackage

// ===== design/spq_cell.sv =====
`timescale 1ns / 1ps

module spq_cell (
  input  logic              clk_i,
  input  logic              valid_i,
  input  spq_pkg::spq_cmd_t cmd_i,
  input  spq_pkg::spq_link_t left_i,
  input  spq_pkg::spq_link_t right_i,
  output spq_pkg::spq_link_t self_o
);
  import spq_pkg::*;

  logic signed [PriorityWidth-1:0] prio_q, prio_d;
  logic        [DataWidth-1:0]     data_q, data_d;
  logic                            ge;

  // Entry stays ahead of the new one when its priority is equal or higher.
  assign ge = valid_i && (prio_q >= cmd_i.prio);

  always_comb begin
    prio_d = prio_q;
    data_d = data_q;
    if (cmd_i.push_en) begin
      if (!ge) begin
        if (left_i.ge) begin
          prio_d = cmd_i.prio;
          data_d = cmd_i.data;
        end else begin
          prio_d = left_i.prio;
          data_d = left_i.data;
        end
      end
    end else if (cmd_i.pop_en) begin
      prio_d = right_i.prio;
      data_d = right_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    data_q <= data_d;
  end

  assign self_o.ge   = ge;
  assign self_o.prio = prio_q;
  assign self_o.data = data_q;

endmodule

// ===== design/stable_priority_queue_top.sv =====
`timescale 1ns / 1ps
// The result strobe done_o is registered and rises in the cycle after the item is accepted.
// Throughput: one item per cycle; busy is never raised, since every cell of
// the chain compares against the pushed priority and shifts in the same cycle.
// Reset: asynchronous, active low; clears the entry count and the strobe.
// Results cannot be stalled by the receiver: each is shown for one cycle.
module stable_priority_queue_top (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start,
  output logic                                      busy,
  input  logic [1:0]                                action_i,
  input  logic signed [spq_pkg::PriorityWidth-1:0]  priority_req_i,
  input  logic [spq_pkg::DataWidth-1:0]             data_in_i,
  output logic                                      done_o,
  output logic [1:0]                                status_o,
  output logic [spq_pkg::DataWidth-1:0]             data_out_o,
  output logic signed [spq_pkg::PriorityWidth-1:0]  head_priority_o,
  output logic [spq_pkg::CountWidth-1:0]            entry_count_o
);
  import spq_pkg::*;

  logic [CountWidth-1:0]            occ_q, occ_d;
  logic                             done_q;
  status_e                          status_q, status_d;
  logic [DataWidth-1:0]             dout_q, dout_d;
  logic signed [PriorityWidth-1:0]  pout_q, pout_d;

  logic      accept, is_empty, is_full;
  action_e   act;
  spq_cmd_t  cmd;
  spq_link_t links [QueueDepth];
  spq_link_t head_link, tail_link;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign act      = action_e'(action_i);
  assign is_empty = (occ_q == '0);
  assign is_full  = (occ_q == CountWidth'(QueueDepth));

  assign cmd.push_en = accept && (act == ACT_PUSH) && !is_full;
  assign cmd.pop_en  = accept && (act == ACT_POP) && !is_empty;
  assign cmd.prio    = priority_req_i;
  assign cmd.data    = data_in_i;

  // Left of the head: new entry goes in at the first cell not ahead of it.
  assign head_link.ge   = 1'b1;
  assign head_link.prio = '0;
  assign head_link.data = '0;
  assign tail_link.ge   = 1'b0;
  assign tail_link.prio = '0;
  assign tail_link.data = '0;

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic      valid;
    spq_link_t left, right;
    assign valid = (occ_q > CountWidth'(i));
    if (i == 0) begin : g_first
      assign left = head_link;
    end else begin : g_mid
      assign left = links[i-1];
    end
    if (i == QueueDepth - 1) begin : g_last
      assign right = tail_link;
    end else begin : g_body
      assign right = links[i+1];
    end
    spq_cell u_cell (
      .clk_i   (clk_i),
      .valid_i (valid),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .self_o  (links[i])
    );
  end

  always_comb begin
    occ_d    = occ_q;
    status_d = ST_OK;
    dout_d   = '0;
    pout_d   = '0;
    case (act)
      ACT_PUSH: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          occ_d = occ_q + 1'b1;
        end
      end
      ACT_POP, ACT_PEEK: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          dout_d = links[0].data;
          pout_d = links[0].prio;
          if (act == ACT_POP) begin
            occ_d = occ_q - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        occ_q <= occ_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      dout_q   <= dout_d;
      pout_q   <= pout_d;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign data_out_o      = dout_q;
  assign head_priority_o = pout_q;
  assign entry_count_o   = occ_q;

endmodule

// ===== design/spq_checker.sv =====
`timescale 1ns / 1ps

module spq_checker (
  input logic                                      clk_i,
  input logic                                      rst_ni,
  input logic                                      start,
  input logic                                      busy,
  input logic                                      done_o,
  input logic [1:0]                                status_o,
  input logic [spq_pkg::DataWidth-1:0]             data_out_o,
  input logic signed [spq_pkg::PriorityWidth-1:0]  head_priority_o,
  input logic [spq_pkg::CountWidth-1:0]            entry_count_o
);
  import spq_pkg::*;

  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("result strobe missing after accepted item");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result strobe without accepted item");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |->
      (entry_count_o == '0 && data_out_o == '0 && head_priority_o == '0))
    else $error("empty status with nonzero count or payload");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> entry_count_o == CountWidth'(QueueDepth))
    else $error("full status while queue not full");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(done_o)) |->
      (entry_count_o == $past(entry_count_o) ||
       entry_count_o == $past(entry_count_o) + 1'b1 ||
       entry_count_o == $past(entry_count_o) - 1'b1))
    else $error("entry count moved by more than one");

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  typedef enum logic [1:0] {
    K_ITEM,
    K_IDLE,
    K_DRAIN
  } cmd_kind_e;

  typedef struct {
    cmd_kind_e                       kind;
    int                              cycles;
    action_e                         act;
    logic signed [PriorityWidth-1:0] prio;
    logic        [DataWidth-1:0]     data;
  } cmd_t;

  typedef struct {
    status_e                         status;
    logic        [DataWidth-1:0]     data;
    logic signed [PriorityWidth-1:0] prio;
    logic        [CountWidth-1:0]    count;
  } reply_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  logic [1:0]                      action_i = ACT_NOP;
  logic signed [PriorityWidth-1:0] priority_req_i = '0;
  logic [DataWidth-1:0]            data_in_i = '0;
  logic                            done_o;
  logic [1:0]                      status_o;
  logic [DataWidth-1:0]            data_out_o;
  logic signed [PriorityWidth-1:0] head_priority_o;
  logic [CountWidth-1:0]           entry_count_o;

  stable_priority_queue_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .priority_req_i (priority_req_i),
    .data_in_i      (data_in_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .data_out_o     (data_out_o),
    .head_priority_o(head_priority_o),
    .entry_count_o  (entry_count_o)
  );

  cmd_t   cmd_q[$];
  reply_t reply_q[$];
  int     err_cnt = 0;
  int     n_sent = 0;
  int     n_got = 0;
  int     idle_left = 0;

  // Shadow copy of the sorted store, head at index 0.
  logic        [DataWidth-1:0]     shadow_data[QueueDepth];
  logic signed [PriorityWidth-1:0] shadow_prio[QueueDepth];
  int                              shadow_cnt = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("stable_priority_queue_top test failed");
    $finish;
  end

  function automatic reply_t apply_to_shadow(action_e act, logic signed [PriorityWidth-1:0] prio,
                                             logic [DataWidth-1:0] data);
    reply_t r;
    int     pos;
    r.status = ST_OK;
    r.data   = '0;
    r.prio   = '0;
    case (act)
      ACT_PUSH: begin
        if (shadow_cnt >= QueueDepth) begin
          r.status = ST_FULL;
        end else begin
          // new entry goes behind every entry of equal or higher priority
          pos = 0;
          while (pos < shadow_cnt && shadow_prio[pos] >= prio) pos++;
          for (int k = shadow_cnt; k > pos; k--) begin
            shadow_data[k] = shadow_data[k-1];
            shadow_prio[k] = shadow_prio[k-1];
          end
          shadow_data[pos] = data;
          shadow_prio[pos] = prio;
          shadow_cnt++;
        end
      end
      ACT_POP, ACT_PEEK: begin
        if (shadow_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = shadow_data[0];
          r.prio = shadow_prio[0];
          if (act == ACT_POP) begin
            for (int k = 1; k < shadow_cnt; k++) begin
              shadow_data[k-1] = shadow_data[k];
              shadow_prio[k-1] = shadow_prio[k];
            end
            shadow_cnt--;
          end
        end
      end
      default: ;
    endcase
    r.count = shadow_cnt[CountWidth-1:0];
    return r;
  endfunction

  task automatic add_item(action_e act, logic signed [PriorityWidth-1:0] prio,
                          logic [DataWidth-1:0] data);
    cmd_t c;
    c.kind   = K_ITEM;
    c.cycles = 0;
    c.act    = act;
    c.prio   = prio;
    c.data   = data;
    cmd_q.push_back(c);
  endtask

  task automatic add_marker(cmd_kind_e kind, int cycles);
    cmd_t c;
    c.kind   = kind;
    c.cycles = cycles;
    c.act    = ACT_NOP;
    c.prio   = '0;
    c.data   = '0;
    cmd_q.push_back(c);
  endtask

  // Skewed toward extremes and a small pool of ties.
  function automatic logic signed [PriorityWidth-1:0] pick_prio();
    int v;
    v = $urandom_range(9, 0);
    if (v == 0) return 16'sh7fff;
    if (v == 1) return 16'sh8000;
    if (v < 6) begin
      v = $urandom_range(6, 0);
      return PriorityWidth'(v - 3);
    end
    return PriorityWidth'($urandom());
  endfunction

  // Driver
  logic    fire;
  logic    go;
  cmd_t    cur;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      fire = start && !busy;
      if (fire) begin
        reply_q.push_back(apply_to_shadow(action_e'(action_i), priority_req_i, data_in_i));
        n_sent++;
      end
      if (!start || fire) begin
        go = 1'b0;
        if (idle_left > 0) begin
          idle_left--;
        end else if (cmd_q.size() != 0) begin
          case (cmd_q[0].kind)
            K_IDLE: begin
              idle_left = cmd_q[0].cycles - 1;
              void'(cmd_q.pop_front());
            end
            K_DRAIN: begin
              if (!fire && n_sent == n_got) void'(cmd_q.pop_front());
            end
            default: begin
              cur = cmd_q.pop_front();
              go  = 1'b1;
            end
          endcase
        end
        start <= go;
        if (go) begin
          action_i       <= cur.act;
          priority_req_i <= cur.prio;
          data_in_i      <= cur.data;
        end
      end
    end
  end

  // Monitor
  reply_t want;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (reply_q.size() == 0) begin
        $error("result with no item outstanding");
        err_cnt++;
      end else begin
        want = reply_q.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          err_cnt++;
        end
        if (data_out_o !== want.data) begin
          $error("data_out: expected %h, got %h", want.data, data_out_o);
          err_cnt++;
        end
        if (head_priority_o !== want.prio) begin
          $error("head_priority: expected %0d, got %0d", want.prio, head_priority_o);
          err_cnt++;
        end
        if (entry_count_o !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count_o);
          err_cnt++;
        end
      end
      n_got <= n_got + 1;
    end
  end

  // Stimulus
  int      n_rand;
  int      mode;
  int      seg;
  int      r;
  action_e act;

  initial begin
    // empty queue, unused code, extremes and ties
    add_item(ACT_POP, 16'sh7fff, 32'hffff_ffff);
    add_item(ACT_PEEK, 16'sh8000, 32'h0);
    add_item(ACT_NOP, 16'sh1234, 32'hdead_beef);
    add_item(ACT_PUSH, 16'sh7fff, 32'hffff_ffff);
    add_item(ACT_PUSH, 16'sh8000, 32'h0000_0000);
    add_item(ACT_PUSH, 16'sh0000, 32'h1111_1111);
    add_item(ACT_PUSH, 16'sh0000, 32'h2222_2222);
    add_item(ACT_PUSH, 16'shffff, 32'h3333_3333);
    add_item(ACT_PUSH, 16'sh0000, 32'h4444_4444);
    add_item(ACT_PUSH, 16'sh7fff, 32'h5555_5555);
    add_item(ACT_PEEK, 16'sh0000, 32'h0);
    add_item(ACT_NOP, 16'sh0000, 32'h0);
    repeat (7) add_item(ACT_POP, 16'sh0000, 32'h0);
    add_item(ACT_POP, 16'sh0000, 32'h0);
    add_item(ACT_PEEK, 16'sh0000, 32'h0);
    add_marker(K_DRAIN, 0);

    n_rand = 0;
    while (n_rand < 550) begin
      mode = $urandom_range(2, 0);
      seg  = $urandom_range(40, 10);
      if ($urandom_range(3, 0) == 0) add_marker(K_DRAIN, 0);
      for (int i = 0; i < seg && n_rand < 550; i++) begin
        // no idling in the tail of the run
        if (n_rand < 470 && $urandom_range(4, 0) == 0)
          add_marker(K_IDLE, $urandom_range(14, 1));
        r = $urandom_range(99, 0);
        case (mode)
          0: begin
            if (r < 85) act = ACT_PUSH;
            else if (r < 95) act = ACT_PEEK;
            else act = ACT_POP;
          end
          1: begin
            if (r < 65) act = ACT_POP;
            else if (r < 88) act = ACT_PEEK;
            else if (r < 97) act = ACT_PUSH;
            else act = ACT_NOP;
          end
          default: begin
            if (r < 45) act = ACT_PUSH;
            else if (r < 80) act = ACT_POP;
            else if (r < 97) act = ACT_PEEK;
            else act = ACT_NOP;
          end
        endcase
        add_item(act, pick_prio(), $urandom());
        if (act != ACT_NOP) n_rand++;
      end
    end

    while (cmd_q.size() != 0 || idle_left != 0 || start) @(posedge clk_i);
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("stable_priority_queue_top test passed");
    end else begin
      $display("stable_priority_queue_top test failed");
    end
    $finish;
  end

endmodule
